>>> hw/rtl/rie_pkg.sv
// ----------------------------------------------------------------------------
// rie_pkg
// shared types and constants of the rendezvous ipc engine
// ----------------------------------------------------------------------------
package rie_pkg;

	localparam int PROCS = 16;
	localparam int IDW   = 4;
	localparam int PW    = 5;

	localparam logic [PW-1:0] ANY_SRC = 5'd16;
	localparam logic [PW-1:0] INT_SRC = 5'd17;
	localparam logic [PW-1:0] NONE_Q  = 5'd16;

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_RECV = 2'd1,
		OP_INT  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_DELIVERED = 3'd0,
		ST_BLOCKED   = 3'd1,
		ST_DEADLOCK  = 3'd2,
		ST_BAD       = 3'd3,
		ST_INT_DELIV = 3'd4,
		ST_INT_PEND  = 3'd5
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CALLER = 7'b0000010,
		S_WALK   = 7'b0000100,
		S_SCHK   = 7'b0001000,
		S_RCHK   = 7'b0010000,
		S_UNL    = 7'b0100000,
		S_FIN    = 7'b1000000
	} state_t;

	typedef struct packed {
		status_t        status;
		logic           copy_valid;
		logic           copy_from_interrupt;
		logic [IDW-1:0] copy_src_proc;
		logic [31:0]    copy_src_addr;
		logic [IDW-1:0] copy_dst_proc;
		logic [31:0]    copy_dst_addr;
		logic           woken_valid;
		logic [IDW-1:0] woken_proc;
	} res_t;

endpackage

>>> hw/rtl/rendezvous_ipc_engine.sv
// ----------------------------------------------------------------------------
// rendezvous_ipc_engine
// synchronous send/receive rendezvous with interrupts, deadlock check and sender queues
// ----------------------------------------------------------------------------
// done rises at the end of the caller state for requests decided on the caller's
// entry, and later when the deadlock chain walk or the sender queue walk runs, up to
// all 16 steps; one table entry is read per cycle
// one transaction at a time; a new one is taken at the edge ending the done cycle
// reset clears all process flags and empties all sender queues
// done marks the single result cycle; the receiver cannot stall
module rendezvous_ipc_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [3:0]  caller,
	input  logic [4:0]  peer,
	input  logic [31:0] msg_addr,
	output logic        done,
	output logic [2:0]  status,
	output logic        copy_valid,
	output logic        copy_from_interrupt,
	output logic [3:0]  copy_src_proc,
	output logic [31:0] copy_src_addr,
	output logic [3:0]  copy_dst_proc,
	output logic [31:0] copy_dst_addr,
	output logic        woken_valid,
	output logic [3:0]  woken_proc
);

	localparam int N = rie_pkg::PROCS;

	rie_pkg::state_t state_q;
	rie_pkg::res_t   res_q;
	logic            done_q;

	logic [1:0]  op_q;
	logic [3:0]  me_q;
	logic [4:0]  peer_q;
	logic [31:0] addr_q;
	logic [3:0]  ptr_q;
	logic [4:0]  cnt_q;
	logic [4:0]  head_me_q;
	logic [3:0]  snd_q;
	logic [4:0]  cur_q;
	logic [4:0]  prev_q;

	logic [N-1:0] sending_q;
	logic [N-1:0] receiving_q;
	logic [N-1:0] intpend_q;
	logic [3:0]   target_q [N];
	logic [4:0]   rsrc_q   [N];
	logic [31:0]  saved_q  [N];
	logic [4:0]   qhead_q  [N];
	logic [4:0]   qnext_q  [N];
	logic [3:0]   qtail_q  [N];

	logic        rd_sf, rd_rf, rd_ip;
	logic [3:0]  rd_st, rd_qt;
	logic [4:0]  rd_rs, rd_qh, rd_qn;
	logic [31:0] rd_sa;
	logic [4:0]  me_ext;

	assign rd_sf  = sending_q[ptr_q];
	assign rd_rf  = receiving_q[ptr_q];
	assign rd_ip  = intpend_q[ptr_q];
	assign rd_st  = target_q[ptr_q];
	assign rd_rs  = rsrc_q[ptr_q];
	assign rd_sa  = saved_q[ptr_q];
	assign rd_qh  = qhead_q[ptr_q];
	assign rd_qn  = qnext_q[ptr_q];
	assign rd_qt  = qtail_q[ptr_q];
	assign me_ext = {1'b0, me_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rie_pkg::S_IDLE;
			done_q      <= 1'b0;
			res_q       <= '0;
			op_q        <= '0;
			me_q        <= '0;
			peer_q      <= '0;
			addr_q      <= '0;
			ptr_q       <= '0;
			cnt_q       <= '0;
			head_me_q   <= rie_pkg::NONE_Q;
			snd_q       <= '0;
			cur_q       <= rie_pkg::NONE_Q;
			prev_q      <= rie_pkg::NONE_Q;
			sending_q   <= '0;
			receiving_q <= '0;
			intpend_q   <= '0;
			for (int i = 0; i < N; i++) begin
				target_q[i] <= '0;
				rsrc_q[i]   <= '0;
				saved_q[i]  <= '0;
				qhead_q[i]  <= rie_pkg::NONE_Q;
				qnext_q[i]  <= rie_pkg::NONE_Q;
				qtail_q[i]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				rie_pkg::S_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						me_q    <= caller;
						peer_q  <= peer;
						addr_q  <= msg_addr;
						ptr_q   <= caller;
						state_q <= rie_pkg::S_CALLER;
					end
				end
				rie_pkg::S_CALLER: begin
					head_me_q <= rd_qh;
					if (op_q == rie_pkg::OP_INT) begin
						done_q  <= 1'b1;
						state_q <= rie_pkg::S_IDLE;
						if (rd_rf && (rd_rs == rie_pkg::ANY_SRC || rd_rs == rie_pkg::INT_SRC)) begin
							receiving_q[me_q] <= 1'b0;
							res_q <= '{status: rie_pkg::ST_INT_DELIV, copy_valid: 1'b1,
								copy_from_interrupt: 1'b1, copy_src_proc: '0,
								copy_src_addr: '0, copy_dst_proc: me_q,
								copy_dst_addr: rd_sa, woken_valid: 1'b1, woken_proc: me_q};
						end else begin
							intpend_q[me_q] <= 1'b1;
							res_q <= '{status: rie_pkg::ST_INT_PEND, default: '0};
						end
					end else if ((op_q != rie_pkg::OP_SEND && op_q != rie_pkg::OP_RECV)
						|| rd_sf || rd_rf || peer_q == me_ext
						|| (op_q == rie_pkg::OP_SEND && peer_q[4])
						|| (op_q == rie_pkg::OP_RECV && peer_q > rie_pkg::INT_SRC)) begin
						done_q  <= 1'b1;
						state_q <= rie_pkg::S_IDLE;
						res_q   <= '{status: rie_pkg::ST_BAD, default: '0};
					end else if (op_q == rie_pkg::OP_SEND) begin
						ptr_q   <= peer_q[3:0];
						cnt_q   <= '0;
						state_q <= rie_pkg::S_WALK;
					end else if (rd_ip && peer_q[4]) begin
						intpend_q[me_q] <= 1'b0;
						done_q  <= 1'b1;
						state_q <= rie_pkg::S_IDLE;
						res_q <= '{status: rie_pkg::ST_INT_DELIV, copy_valid: 1'b1,
							copy_from_interrupt: 1'b1, copy_src_proc: '0,
							copy_src_addr: '0, copy_dst_proc: me_q,
							copy_dst_addr: addr_q, woken_valid: 1'b0, woken_proc: '0};
					end else if (peer_q == rie_pkg::ANY_SRC && !rd_qh[4]) begin
						snd_q   <= rd_qh[3:0];
						cur_q   <= rd_qh;
						prev_q  <= rie_pkg::NONE_Q;
						cnt_q   <= '0;
						ptr_q   <= rd_qh[3:0];
						state_q <= rie_pkg::S_UNL;
					end else if (!peer_q[4]) begin
						ptr_q   <= peer_q[3:0];
						state_q <= rie_pkg::S_RCHK;
					end else begin
						receiving_q[me_q] <= 1'b1;
						rsrc_q[me_q]      <= peer_q;
						saved_q[me_q]     <= addr_q;
						done_q  <= 1'b1;
						state_q <= rie_pkg::S_IDLE;
						res_q   <= '{status: rie_pkg::ST_BLOCKED, default: '0};
					end
				end
				rie_pkg::S_WALK: begin
					if (!rd_sf || (rd_st != me_q && cnt_q == 5'(N - 1))) begin
						ptr_q   <= peer_q[3:0];
						state_q <= rie_pkg::S_SCHK;
					end else if (rd_st == me_q) begin
						done_q  <= 1'b1;
						state_q <= rie_pkg::S_IDLE;
						res_q   <= '{status: rie_pkg::ST_DEADLOCK, default: '0};
					end else begin
						ptr_q <= rd_st;
						cnt_q <= cnt_q + 5'd1;
					end
				end
				rie_pkg::S_SCHK: begin
					done_q  <= 1'b1;
					state_q <= rie_pkg::S_IDLE;
					if (rd_rf && (rd_rs == me_ext || rd_rs == rie_pkg::ANY_SRC)) begin
						receiving_q[ptr_q] <= 1'b0;
						res_q <= '{status: rie_pkg::ST_DELIVERED, copy_valid: 1'b1,
							copy_from_interrupt: 1'b0, copy_src_proc: me_q,
							copy_src_addr: addr_q, copy_dst_proc: ptr_q,
							copy_dst_addr: rd_sa, woken_valid: 1'b1, woken_proc: ptr_q};
					end else begin
						sending_q[me_q] <= 1'b1;
						target_q[me_q]  <= ptr_q;
						saved_q[me_q]   <= addr_q;
						if (rd_qh[4]) begin
							qhead_q[ptr_q] <= me_ext;
						end else begin
							qnext_q[rd_qt] <= me_ext;
						end
						qtail_q[ptr_q] <= me_q;
						qnext_q[me_q]  <= rie_pkg::NONE_Q;
						res_q <= '{status: rie_pkg::ST_BLOCKED, default: '0};
					end
				end
				rie_pkg::S_RCHK: begin
					if (rd_sf && rd_st == me_q) begin
						snd_q   <= ptr_q;
						cur_q   <= head_me_q;
						prev_q  <= rie_pkg::NONE_Q;
						cnt_q   <= '0;
						ptr_q   <= head_me_q[3:0];
						state_q <= rie_pkg::S_UNL;
					end else begin
						receiving_q[me_q] <= 1'b1;
						rsrc_q[me_q]      <= peer_q;
						saved_q[me_q]     <= addr_q;
						done_q  <= 1'b1;
						state_q <= rie_pkg::S_IDLE;
						res_q   <= '{status: rie_pkg::ST_BLOCKED, default: '0};
					end
				end
				rie_pkg::S_UNL: begin
					if (cur_q[4] || cnt_q == 5'(N)) begin
						ptr_q   <= snd_q;
						state_q <= rie_pkg::S_FIN;
					end else if (cur_q[3:0] == snd_q) begin
						if (prev_q[4]) begin
							qhead_q[me_q] <= rd_qn;
						end else begin
							qnext_q[prev_q[3:0]] <= rd_qn;
						end
						if (rd_qn[4]) begin
							qtail_q[me_q] <= prev_q[4] ? 4'd0 : prev_q[3:0];
						end
						qnext_q[snd_q]   <= rie_pkg::NONE_Q;
						sending_q[snd_q] <= 1'b0;
						done_q  <= 1'b1;
						state_q <= rie_pkg::S_IDLE;
						res_q <= '{status: rie_pkg::ST_DELIVERED, copy_valid: 1'b1,
							copy_from_interrupt: 1'b0, copy_src_proc: snd_q,
							copy_src_addr: rd_sa, copy_dst_proc: me_q,
							copy_dst_addr: addr_q, woken_valid: 1'b1, woken_proc: snd_q};
					end else begin
						prev_q <= cur_q;
						cur_q  <= rd_qn;
						ptr_q  <= rd_qn[3:0];
						cnt_q  <= cnt_q + 5'd1;
					end
				end
				rie_pkg::S_FIN: begin
					sending_q[snd_q] <= 1'b0;
					done_q  <= 1'b1;
					state_q <= rie_pkg::S_IDLE;
					res_q <= '{status: rie_pkg::ST_DELIVERED, copy_valid: 1'b1,
						copy_from_interrupt: 1'b0, copy_src_proc: snd_q,
						copy_src_addr: rd_sa, copy_dst_proc: me_q,
						copy_dst_addr: addr_q, woken_valid: 1'b1, woken_proc: snd_q};
				end
				default: begin
					state_q <= rie_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign busy                = (state_q != rie_pkg::S_IDLE);
	assign done                = done_q;
	assign status              = res_q.status;
	assign copy_valid          = res_q.copy_valid;
	assign copy_from_interrupt = res_q.copy_from_interrupt;
	assign copy_src_proc       = res_q.copy_src_proc;
	assign copy_src_addr       = res_q.copy_src_addr;
	assign copy_dst_proc       = res_q.copy_dst_proc;
	assign copy_dst_addr       = res_q.copy_dst_addr;
	assign woken_valid         = res_q.woken_valid;
	assign woken_proc          = res_q.woken_proc;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result issued while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not start work");

	a_no_copy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !copy_valid |-> copy_src_addr == 32'd0 && copy_dst_addr == 32'd0)
		else $error("copy fields not cleared");

	a_delivered_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == rie_pkg::ST_DELIVERED |-> copy_valid && woken_valid)
		else $error("delivery without copy or wake");

endmodule
